// File: src/qep_pkg.sv
// ----------------------------------------------------------------------------
// qep_pkg
// Shared types, constants and the quadrature step table for the encoder
// position tracker.
// ----------------------------------------------------------------------------
package qep_pkg;

   // Default number of tracked encoders
   localparam int NUM_ENCODERS_DEF = 5;

   // Field widths
   localparam int ENC_W  = 3;
   localparam int POS_W  = 8;
   localparam int HOME_W = 8;
   localparam int STEP_W = 3;

   // Register reset values
   localparam logic [POS_W-1:0]  POSITION_MAX_RST     = 8'd0;
   localparam logic [HOME_W-1:0] HOMING_THRESHOLD_RST = 8'd30;

   // Position code that means underflow below zero
   localparam logic [POS_W-1:0] POS_UNDERFLOW = 8'hFF;

   // Step codes
   localparam logic signed [STEP_W-1:0] STEP_NONE = 3'sd0;
   localparam logic signed [STEP_W-1:0] STEP_UP   = 3'sd1;
   localparam logic signed [STEP_W-1:0] STEP_DOWN = -3'sd1;
   localparam logic signed [STEP_W-1:0] STEP_SKIP = 3'sd2;

   // Indexed by {old_a, old_b, new_a, new_b}
   localparam logic signed [STEP_W-1:0] STEP_TABLE [16] = '{
      STEP_NONE, STEP_DOWN, STEP_UP,   STEP_SKIP,
      STEP_UP,   STEP_NONE, STEP_SKIP, STEP_DOWN,
      STEP_DOWN, STEP_SKIP, STEP_NONE, STEP_UP,
      STEP_SKIP, STEP_UP,   STEP_DOWN, STEP_NONE
   };

   // Register map (word index)
   typedef enum logic {
      REG_POSITION_MAX     = 1'b0,
      REG_HOMING_THRESHOLD = 1'b1
   } qep_reg_type;

   typedef struct packed {
      logic [POS_W-1:0]  position_max;
      logic [HOME_W-1:0] homing_threshold;
   } qep_cfg_type;

   typedef struct packed {
      logic              last_a;
      logic              last_b;
      logic [POS_W-1:0]  position;
      logic [HOME_W-1:0] homing;
   } qep_enc_state_type;

endpackage

// File: src/qep_req_if.sv
// ----------------------------------------------------------------------------
// qep_req_if
// Pin-edge event channel: valid/ready handshake with encoder, pin and level.
// ----------------------------------------------------------------------------
interface qep_req_if;
   logic                       valid;
   logic                       ready;
   logic [qep_pkg::ENC_W-1:0]  encoder_index;
   logic                       channel;
   logic                       level;

   modport source (output valid, output encoder_index, output channel,
                   output level, input ready);
   modport sink   (input valid, input encoder_index, input channel,
                   input level, output ready);
endinterface

// File: src/qep_rsp_if.sv
// ----------------------------------------------------------------------------
// qep_rsp_if
// Position result channel: valid/ready handshake with position and step.
// ----------------------------------------------------------------------------
interface qep_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [qep_pkg::ENC_W-1:0]         encoder_id;
   logic [qep_pkg::POS_W-1:0]         position;
   logic signed [qep_pkg::STEP_W-1:0] step;
   logic                              skipped;

   modport source (output valid, output encoder_id, output position,
                   output step, output skipped, input ready);
   modport sink   (input valid, input encoder_id, input position,
                   input step, input skipped, output ready);
endinterface

// File: src/qep_csr.sv
// ----------------------------------------------------------------------------
// qep_csr
// APB-style register block holding position_max and homing_threshold.
// ----------------------------------------------------------------------------
module qep_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output qep_pkg::qep_cfg_type cfg
);

   qep_pkg::qep_cfg_type cfg_ff;
   qep_pkg::qep_cfg_type cfg_in;
   qep_pkg::qep_reg_type reg_sel;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_sel = qep_pkg::qep_reg_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            qep_pkg::REG_POSITION_MAX: begin
               cfg_in.position_max = pwdata[qep_pkg::POS_W-1:0];
            end
            qep_pkg::REG_HOMING_THRESHOLD: begin
               cfg_in.homing_threshold = pwdata[qep_pkg::HOME_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         qep_pkg::REG_POSITION_MAX: begin
            prdata = {{(32-qep_pkg::POS_W){1'b0}}, cfg_ff.position_max};
         end
         qep_pkg::REG_HOMING_THRESHOLD: begin
            prdata = {{(32-qep_pkg::HOME_W){1'b0}}, cfg_ff.homing_threshold};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_max     <= qep_pkg::POSITION_MAX_RST;
         cfg_ff.homing_threshold <= qep_pkg::HOMING_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/qep_calc.sv
// ----------------------------------------------------------------------------
// qep_calc
// Next-state logic for one encoder: step lookup, position update, homing
// counter and clamping.
// ----------------------------------------------------------------------------
module qep_calc (
   input  qep_pkg::qep_cfg_type             cfg,
   input  qep_pkg::qep_enc_state_type       cur,
   input  logic                             channel,
   input  logic                             level,
   output qep_pkg::qep_enc_state_type       nxt,
   output logic signed [qep_pkg::STEP_W-1:0] step,
   output logic                             skipped
);

   logic                         new_a;
   logic                         new_b;
   logic [3:0]                   tbl_idx;
   logic [qep_pkg::POS_W-1:0]    pos_sum;
   logic [qep_pkg::POS_W-1:0]    pos_out;
   logic [qep_pkg::HOME_W-1:0]   home_out;

   assign new_a   = channel ? cur.last_a : level;
   assign new_b   = channel ? level : cur.last_b;
   assign tbl_idx = {cur.last_a, cur.last_b, new_a, new_b};
   assign step    = qep_pkg::STEP_TABLE[tbl_idx];
   assign skipped = (step == qep_pkg::STEP_SKIP);

   // skip steps add +2 like any other step
   assign pos_sum = cur.position
                  + {{(qep_pkg::POS_W-qep_pkg::STEP_W){step[qep_pkg::STEP_W-1]}}, step};

   always_comb begin
      priority if (step == qep_pkg::STEP_UP) begin
         home_out = cur.homing + 8'd1;
      end else if (step == qep_pkg::STEP_DOWN) begin
         home_out = '0;
      end else begin
         home_out = cur.homing;
      end
   end

   always_comb begin
      pos_out = pos_sum;
      if (home_out > cfg.homing_threshold) begin
         pos_out = '0;
      end
      if (pos_out == qep_pkg::POS_UNDERFLOW) begin
         pos_out = cfg.position_max;
      end
      if (pos_out > cfg.position_max) begin
         pos_out = '0;
      end
   end

   assign nxt.last_a   = new_a;
   assign nxt.last_b   = new_b;
   assign nxt.position = pos_out;
   assign nxt.homing   = home_out;

endmodule

// File: src/quadrature_encoder_position.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_position
// Multi-encoder quadrature position tracker with homing and clamping.
// ----------------------------------------------------------------------------
// Accepts one pin-edge event per clock cycle while the result side is not
// stalled and returns one position result per event for a known encoder,
// by way of the input register and then the result register. Events for an
// encoder index at or above NUM_ENCODERS are dropped without a result or a
// state change. Per-encoder state (last A/B levels, position, homing counter)
// sits in flip-flops and is read, updated and written back between the input
// register and the result register, so back-to-back events on the same
// encoder see each other's updates. A stalled result register holds the
// input register, and the input side keeps accepting while either stage is
// free. Registers: position_max at byte 0, homing_threshold at byte 4.
// ----------------------------------------------------------------------------
module quadrature_encoder_position #(
   parameter int NUM_ENCODERS = qep_pkg::NUM_ENCODERS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   qep_req_if.sink            req_ch,
   qep_rsp_if.source          rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   qep_pkg::qep_cfg_type        cfg;
   qep_pkg::qep_enc_state_type  enc_state_ff [NUM_ENCODERS];
   qep_pkg::qep_enc_state_type  enc_state_in [NUM_ENCODERS];
   qep_pkg::qep_enc_state_type  cur_state;
   qep_pkg::qep_enc_state_type  nxt_state;

   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic [qep_pkg::ENC_W-1:0]        s1_enc_ff;
   logic                             s1_channel_ff;
   logic                             s1_level_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [qep_pkg::ENC_W-1:0]        rsp_enc_ff;
   logic [qep_pkg::POS_W-1:0]        rsp_pos_ff;
   logic signed [qep_pkg::STEP_W-1:0] rsp_step_ff;
   logic                             rsp_skip_ff;

   logic signed [qep_pkg::STEP_W-1:0] calc_step;
   logic                             calc_skip;
   logic                             s1_known;
   logic                             out_free;
   logic                             s1_fire;
   logic                             commit;
   logic                             req_xfer;

   qep_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_comb begin
      cur_state = '0;
      for (int k = 0; k < NUM_ENCODERS; k++) begin
         if (int'(s1_enc_ff) == k) begin
            cur_state = enc_state_ff[k];
         end
      end
   end

   qep_calc u_calc (
      .cfg     (cfg),
      .cur     (cur_state),
      .channel (s1_channel_ff),
      .level   (s1_level_ff),
      .nxt     (nxt_state),
      .step    (calc_step),
      .skipped (calc_skip)
   );

   assign s1_known     = int'(s1_enc_ff) < NUM_ENCODERS;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   // unknown encoders leave the input stage without needing the output
   assign s1_fire      = s1_valid_ff && (!s1_known || out_free);
   assign commit       = s1_valid_ff && s1_known && out_free;
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = commit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_comb begin
      for (int k = 0; k < NUM_ENCODERS; k++) begin
         if (commit && (int'(s1_enc_ff) == k)) begin
            enc_state_in[k] = nxt_state;
         end else begin
            enc_state_in[k] = enc_state_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_ENCODERS; k++) begin
            enc_state_ff[k] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NUM_ENCODERS; k++) begin
            enc_state_ff[k] <= enc_state_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_enc_ff     <= req_ch.encoder_index;
         s1_channel_ff <= req_ch.channel;
         s1_level_ff   <= req_ch.level;
      end
      if (commit) begin
         rsp_enc_ff  <= s1_enc_ff;
         rsp_pos_ff  <= nxt_state.position;
         rsp_step_ff <= calc_step;
         rsp_skip_ff <= calc_skip;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.encoder_id = rsp_enc_ff;
   assign rsp_ch.position   = rsp_pos_ff;
   assign rsp_ch.step       = rsp_step_ff;
   assign rsp_ch.skipped    = rsp_skip_ff;

endmodule

// File: src/qep_checker.sv
// ----------------------------------------------------------------------------
// qep_checker
// Port-level checks for the encoder position tracker, bound to the top level.
// ----------------------------------------------------------------------------
module qep_checker #(
   parameter int NUM_ENCODERS = qep_pkg::NUM_ENCODERS_DEF
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [qep_pkg::ENC_W-1:0]         rsp_encoder_id,
   input logic [qep_pkg::POS_W-1:0]         rsp_position,
   input logic signed [qep_pkg::STEP_W-1:0] rsp_step,
   input logic                              rsp_skipped
);

   // the input side only stalls behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while result side is free");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_encoder_id) < NUM_ENCODERS))
      else $error("result for an unknown encoder");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position)
                                     && $stable(rsp_step)))
      else $error("stalled result transfer changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_skipped == (rsp_step == qep_pkg::STEP_SKIP)))
      else $error("skip flag disagrees with step");

endmodule

bind quadrature_encoder_position qep_checker #(
   .NUM_ENCODERS (NUM_ENCODERS)
) u_qep_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_encoder_id (rsp_ch.encoder_id),
   .rsp_position   (rsp_ch.position),
   .rsp_step       (rsp_ch.step),
   .rsp_skipped    (rsp_ch.skipped)
);
